// ===== design/lwpe_pkg.sv =====
// Shared types, constants and the grey-to-color table of the palette expander.
`timescale 1ns / 1ps
package lwpe_pkg;

	localparam int unsigned LANES          = 32;
	localparam int unsigned INDEX_W        = 14;
	localparam int unsigned WORD_W         = 32;
	localparam int unsigned PIX_INDEX_W    = 19;
	localparam int unsigned GREY_W         = 4;
	localparam int unsigned RGB_W          = 16;
	localparam int unsigned COUNT_W        = 5;
	localparam int unsigned FRAME_WORDS_DEF = 16384;

	// Depth codes; the unused code behaves as four bits per pixel.
	localparam logic [1:0] DEPTH_1BPP = 2'd0;
	localparam logic [1:0] DEPTH_2BPP = 2'd1;
	localparam logic [1:0] DEPTH_4BPP = 2'd2;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_DEPTH_CODE   = 2'd0,
		CFG_PALETTE_LOW  = 2'd1,
		CFG_PALETTE_HIGH = 2'd2
	} cfg_index_t;

	// Per-word control handed from the lane array to the output stage.
	typedef struct packed {
		logic [PIX_INDEX_W-1:0] base;
		logic [COUNT_W-1:0]     last_count;
	} emit_ctrl_t;

	// Fixed color ramp for the grey levels, in RGB565 packing.
	function automatic logic [RGB_W-1:0] grey_to_rgb(input logic [GREY_W-1:0] grey);
		logic [RGB_W-1:0] rgb;
		case (grey)
			4'd0:    rgb = 16'ha62f;
			4'd1:    rgb = 16'h9dae;
			4'd2:    rgb = 16'h954d;
			4'd3:    rgb = 16'h84ec;
			4'd4:    rgb = 16'h7c8b;
			4'd5:    rgb = 16'h6c0a;
			4'd6:    rgb = 16'h63a9;
			4'd7:    rgb = 16'h5b48;
			4'd8:    rgb = 16'h4ac7;
			4'd9:    rgb = 16'h4266;
			4'd10:   rgb = 16'h3205;
			4'd11:   rgb = 16'h29a4;
			4'd12:   rgb = 16'h2123;
			4'd13:   rgb = 16'h10c2;
			4'd14:   rgb = 16'h0861;
			default: rgb = 16'h0000;
		endcase
		return rgb;
	endfunction

endpackage

// ===== design/lwpe_lane.sv =====
// One pixel lane: extracts its pixel value and looks up the palette grey level.
`timescale 1ns / 1ps
module lwpe_lane #(
	parameter int unsigned LANE = 0
) (
	input  logic [lwpe_pkg::WORD_W-1:0] pixel_word,
	input  logic [1:0]                  depth_code,
	input  logic [lwpe_pkg::WORD_W-1:0] palette_low,
	input  logic [lwpe_pkg::WORD_W-1:0] palette_high,
	output logic [lwpe_pkg::GREY_W-1:0] grey
);
	import lwpe_pkg::*;

	// Bit positions of this lane's pixel at each depth, kept inside the word.
	localparam int unsigned POS2 = (2 * LANE) % WORD_W;
	localparam int unsigned POS4 = (4 * LANE) % WORD_W;

	logic [3:0]        value;
	logic [WORD_W-1:0] pal;
	logic [2:0]        nib;

	// Pick the pixel value for the current depth.
	always_comb begin
		case (depth_code)
			DEPTH_1BPP: value = {3'd0, pixel_word[LANE]};
			DEPTH_2BPP: value = {2'd0, pixel_word[POS2 +: 2]};
			default:    value = pixel_word[POS4 +: 4];
		endcase
	end

	// Values eight and up read the high palette word.
	assign pal  = value[3] ? palette_high : palette_low;
	assign nib  = value[2:0];
	assign grey = pal[{nib, 2'b00} +: GREY_W];

endmodule

// ===== design/lwpe_emit.sv =====
// Output stage: holds one word's lane results and sends them one pixel per cycle.
`timescale 1ns / 1ps
module lwpe_emit (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      load,
	input  lwpe_pkg::emit_ctrl_t                      ctrl,
	input  logic [lwpe_pkg::LANES-1:0][lwpe_pkg::GREY_W-1:0] greys,
	output logic                                      ready,
	output logic                                      strobe,
	output logic [lwpe_pkg::PIX_INDEX_W-1:0]          pixel_index,
	output logic [lwpe_pkg::GREY_W-1:0]               grey_level,
	output logic [lwpe_pkg::RGB_W-1:0]                rgb565,
	output logic                                      last_pixel
);
	import lwpe_pkg::*;

	logic                          active_q;
	logic [COUNT_W-1:0]            count_q;
	emit_ctrl_t                    ctrl_q;
	logic [LANES-1:0][GREY_W-1:0]  grey_q;
	logic                          strobe_q;
	logic                          last_pixel_q;
	logic [PIX_INDEX_W-1:0]        pixel_index_q;
	logic [GREY_W-1:0]             grey_level_q;
	logic [RGB_W-1:0]              rgb565_q;
	logic                          at_last;
	logic [GREY_W-1:0]             cur_grey;

	assign at_last  = (count_q == ctrl_q.last_count);
	assign ready    = !active_q || at_last;
	assign cur_grey = grey_q[count_q];

	// Sequencing of the pixel counter and the result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= 1'b0;
			count_q      <= '0;
			strobe_q     <= 1'b0;
			last_pixel_q <= 1'b0;
		end else begin
			strobe_q     <= active_q;
			last_pixel_q <= active_q && at_last;
			if (load) begin
				active_q <= 1'b1;
				count_q  <= '0;
			end else if (active_q) begin
				if (at_last) begin
					active_q <= 1'b0;
				end else begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

	// Word buffer and registered result fields.
	always_ff @(posedge clk) begin
		if (load) begin
			ctrl_q <= ctrl;
			grey_q <= greys;
		end
		pixel_index_q <= ctrl_q.base + {{(PIX_INDEX_W-COUNT_W){1'b0}}, count_q};
		grey_level_q  <= cur_grey;
		rgb565_q      <= grey_to_rgb(cur_grey);
	end

	assign strobe      = strobe_q;
	assign pixel_index = pixel_index_q;
	assign grey_level  = grey_level_q;
	assign rgb565      = rgb565_q;
	assign last_pixel  = last_pixel_q;

`ifndef SYNTHESIS
	a_last_has_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		last_pixel |-> strobe)
		else $error("last_pixel without strobe");
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(load && active_q) |-> at_last)
		else $error("word loaded while previous word still emitting");
	a_word_continuous: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last_pixel) |=> strobe)
		else $error("gap inside a word's results");
	a_last_ends_word: assert property (@(posedge clk) disable iff (!arst_n)
		(active_q && at_last && !load) |=> !active_q)
		else $error("emitter stayed active past the last pixel");
`endif

endmodule

// ===== design/lcd_word_palette_expand_top.sv =====
// Top level of the packed-pixel palette expander: registers, input holding stage, lanes.
// The first result is strobed after the holding register, the emit active flag and the strobe
// register. One result per cycle, set by the single output port of the emit stage, while a word
// is emitted; a word has 32, 16 or 8 pixels at 1, 2 or 4 bits per pixel. busy is high for the
// cycle after each in-frame accept and stays so while the emit stage still holds an earlier word.
// Words at or beyond the frame size are dropped and produce no results.
// Reset is asynchronous: depth returns to four bits per pixel, palettes to zero, queue empty.
`timescale 1ns / 1ps
module lcd_word_palette_expand_top #(
	parameter int unsigned FRAME_WORDS = lwpe_pkg::FRAME_WORDS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [lwpe_pkg::INDEX_W-1:0]       word_index,
	input  logic [lwpe_pkg::WORD_W-1:0]        pixel_word,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [1:0]                         cfg_index,
	input  logic [lwpe_pkg::WORD_W-1:0]        cfg_data,
	output logic                               strobe,
	output logic [lwpe_pkg::PIX_INDEX_W-1:0]   pixel_index,
	output logic [lwpe_pkg::GREY_W-1:0]        grey_level,
	output logic [lwpe_pkg::RGB_W-1:0]         rgb565,
	output logic                               last_pixel
);
	import lwpe_pkg::*;

	logic [1:0]                   depth_q;
	logic [WORD_W-1:0]            pal_low_q;
	logic [WORD_W-1:0]            pal_high_q;
	logic                         pend_valid_q;
	logic [INDEX_W-1:0]           pend_index_q;
	logic [WORD_W-1:0]            pend_word_q;
	logic                         accept;
	logic                         in_frame;
	logic                         emit_ready;
	logic                         load;
	emit_ctrl_t                   ctrl;
	logic [LANES-1:0][GREY_W-1:0] greys;
	logic [PIX_INDEX_W-1:0]       index_ext;

	assign cfg_ready = 1'b1;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q    <= DEPTH_4BPP;
			pal_low_q  <= '0;
			pal_high_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index_t'(cfg_index))
				CFG_DEPTH_CODE:   depth_q    <= cfg_data[1:0];
				CFG_PALETTE_LOW:  pal_low_q  <= cfg_data;
				CFG_PALETTE_HIGH: pal_high_q <= cfg_data;
				default:          ;
			endcase
		end
	end

	// Input holding stage: one word waits here while the emit stage drains.
	assign accept   = start && !busy;
	assign in_frame = ({{(32-INDEX_W){1'b0}}, word_index} < 32'(FRAME_WORDS));
	assign load     = pend_valid_q && emit_ready;
	assign busy     = pend_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (accept) begin
			pend_valid_q <= in_frame;
		end else if (load) begin
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pend_index_q <= word_index;
			pend_word_q  <= pixel_word;
		end
	end

	// Word base pixel number and final pixel position for the current depth.
	assign index_ext = {{(PIX_INDEX_W-INDEX_W){1'b0}}, pend_index_q};

	always_comb begin
		case (depth_q)
			DEPTH_1BPP: begin
				ctrl.base       = index_ext << 5;
				ctrl.last_count = 5'd31;
			end
			DEPTH_2BPP: begin
				ctrl.base       = index_ext << 4;
				ctrl.last_count = 5'd15;
			end
			default: begin
				ctrl.base       = index_ext << 3;
				ctrl.last_count = 5'd7;
			end
		endcase
	end

	// Lane array: every pixel slot of the word is looked up at once.
	for (genvar k = 0; k < LANES; k++) begin : g_lane
		lwpe_lane #(
			.LANE(k)
		) u_lane (
			.pixel_word  (pend_word_q),
			.depth_code  (depth_q),
			.palette_low (pal_low_q),
			.palette_high(pal_high_q),
			.grey        (greys[k])
		);
	end

	// Merge stage: collects the lane results and sends them in pixel order.
	lwpe_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load),
		.ctrl       (ctrl),
		.greys      (greys),
		.ready      (emit_ready),
		.strobe     (strobe),
		.pixel_index(pixel_index),
		.grey_level (grey_level),
		.rgb565     (rgb565),
		.last_pixel (last_pixel)
	);

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_frame) |=> busy)
		else $error("accepted word not held");
	a_drop_out_of_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !in_frame) |=> !busy)
		else $error("out-of-frame word was kept");
	a_pending_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && emit_ready) |=> !busy)
		else $error("pending word not loaded when emit stage free");
`endif

endmodule
